// ===== design/htms_pkg.sv =====
// Shared types, constants and arc-tangent table for the heading/thrust motion step block.
// No dependencies; used by every module of the block.
package htms_pkg;

  localparam int PC_W      = 4;
  localparam int ITER_W    = 5;
  localparam int ATAN_LEN  = 24;

  localparam logic signed [23:0] VEL_MAX    = 24'sh7FFFFF;
  localparam logic signed [23:0] VEL_MIN    = -24'sh800000;
  localparam logic signed [23:0] FIELD_HALF = 24'sd512000;
  localparam logic signed [23:0] FIELD_SPAN = 24'sd1024000;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [17:0] TRIG_MAX   = 18'sd65536;
  localparam logic signed [17:0] TRIG_MIN   = -18'sd65536;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_HEAD_MUL,
    OP_HEAD_UPD,
    OP_CORDIC_INIT,
    OP_CORDIC_ITER,
    OP_SINCOS,
    OP_MUL_STHR,
    OP_MUL_CTHR,
    OP_MUL_PDT,
    OP_VX_UPD,
    OP_VY_UPD,
    OP_MUL_VXDT,
    OP_MUL_VYDT,
    OP_PX_UPD,
    OP_PY_UPD,
    OP_EMIT
  } op_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  typedef struct packed {
    op_t             op;
    logic            jump;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic load;
    op_t  op;
  } dp_ctrl_t;

  typedef struct packed {
    logic iter_last;
  } dp_status_t;

  // atan(2^-i) in 2^-32 turn units
  function automatic logic [31:0] atan_turns(input logic [ITER_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ===== design/htms_ucode.sv =====
// Control store: one control word per program step of the motion update.
// Depends on htms_pkg.
module htms_ucode (
  input  logic [htms_pkg::PC_W-1:0] pc,
  output htms_pkg::ctrl_word_t      word
);

  always_comb begin
    word.jump   = 1'b0;
    word.target = '0;
    case (pc)
      4'd0:  word.op = htms_pkg::OP_HEAD_MUL;
      4'd1:  word.op = htms_pkg::OP_HEAD_UPD;
      4'd2:  word.op = htms_pkg::OP_CORDIC_INIT;
      4'd3: begin
        word.op     = htms_pkg::OP_CORDIC_ITER;
        word.jump   = 1'b1;
        word.target = 4'd3;
      end
      4'd4:  word.op = htms_pkg::OP_SINCOS;
      4'd5:  word.op = htms_pkg::OP_MUL_STHR;
      4'd6:  word.op = htms_pkg::OP_MUL_PDT;
      4'd7:  word.op = htms_pkg::OP_VX_UPD;
      4'd8:  word.op = htms_pkg::OP_MUL_CTHR;
      4'd9:  word.op = htms_pkg::OP_MUL_PDT;
      4'd10: word.op = htms_pkg::OP_VY_UPD;
      4'd11: word.op = htms_pkg::OP_MUL_VXDT;
      4'd12: word.op = htms_pkg::OP_PX_UPD;
      4'd13: word.op = htms_pkg::OP_MUL_VYDT;
      4'd14: word.op = htms_pkg::OP_PY_UPD;
      4'd15: word.op = htms_pkg::OP_EMIT;
      default: word.op = htms_pkg::OP_NOP;
    endcase
  end

endmodule

// ===== design/htms_datapath.sv =====
// Datapath: shared multiplier, CORDIC rotator, saturation and wrap, motion state.
// Depends on htms_pkg; driven by the control words of htms_ucode.
module htms_datapath #(
  parameter int ITERS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  htms_pkg::dp_ctrl_t       ctrl,
  input  logic [15:0]              time_step,
  input  logic signed [15:0]       turn_rate,
  input  logic signed [19:0]       thrust,
  output htms_pkg::dp_status_t     status,
  output logic signed [19:0]       pos_x,
  output logic signed [19:0]       pos_y,
  output logic signed [23:0]       vel_x,
  output logic signed [23:0]       vel_y,
  output logic [15:0]              angle
);

  logic [15:0]                          dt;
  logic signed [15:0]                   rate;
  logic signed [19:0]                   thr;
  logic [15:0]                          heading;
  logic signed [33:0]                   cx;
  logic signed [33:0]                   cy;
  logic signed [31:0]                   cz;
  logic                                 flip;
  logic [htms_pkg::ITER_W-1:0]          cnt;
  logic signed [17:0]                   sin_v;
  logic signed [17:0]                   cos_v;
  logic signed [57:0]                   prod;
  logic signed [23:0]                   vx;
  logic signed [23:0]                   vy;
  logic signed [23:0]                   px;
  logic signed [23:0]                   py;

  logic signed [37:0]                   mul_a;
  logic signed [19:0]                   mul_b;
  logic signed [57:0]                   mul_p;
  logic signed [19:0]                   dt_s;
  logic signed [33:0]                   dx;
  logic signed [33:0]                   dy;
  logic [31:0]                          atan_v;
  logic signed [15:0]                   z16;
  logic signed [26:0]                   vx_sum;
  logic signed [26:0]                   vy_sum;
  logic signed [26:0]                   px_sum;
  logic signed [26:0]                   py_sum;
  logic signed [17:0]                   cos_c;
  logic signed [17:0]                   sin_c;

  function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
    if (v > 27'(htms_pkg::VEL_MAX)) return htms_pkg::VEL_MAX;
    if (v < 27'(htms_pkg::VEL_MIN)) return htms_pkg::VEL_MIN;
    return v[23:0];
  endfunction

  function automatic logic signed [23:0] wrap(input logic signed [23:0] p);
    if (p > htms_pkg::FIELD_HALF) return p - htms_pkg::FIELD_SPAN;
    if (p < -htms_pkg::FIELD_HALF) return p + htms_pkg::FIELD_SPAN;
    return p;
  endfunction

  function automatic logic signed [17:0] sat_trig(input logic signed [19:0] v);
    if (v > 20'(htms_pkg::TRIG_MAX)) return htms_pkg::TRIG_MAX;
    if (v < 20'(htms_pkg::TRIG_MIN)) return htms_pkg::TRIG_MIN;
    return v[17:0];
  endfunction

  assign dt_s = $signed({4'b0000, dt});

  always_comb begin
    case (ctrl.op)
      htms_pkg::OP_HEAD_MUL: begin
        mul_a = 38'(rate);
        mul_b = dt_s;
      end
      htms_pkg::OP_MUL_STHR: begin
        mul_a = 38'(sin_v);
        mul_b = thr;
      end
      htms_pkg::OP_MUL_CTHR: begin
        mul_a = 38'(cos_v);
        mul_b = thr;
      end
      htms_pkg::OP_MUL_PDT: begin
        mul_a = prod[37:0];
        mul_b = dt_s;
      end
      htms_pkg::OP_MUL_VXDT: begin
        mul_a = 38'(vx);
        mul_b = dt_s;
      end
      htms_pkg::OP_MUL_VYDT: begin
        mul_a = 38'(vy);
        mul_b = dt_s;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p  = 58'(mul_a) * 58'(mul_b);

  assign dx     = cy >>> cnt;
  assign dy     = cx >>> cnt;
  assign atan_v = htms_pkg::atan_turns(cnt);
  assign z16    = (heading[15] ^ heading[14]) ? $signed({~heading[15], heading[14:0]})
                                              : $signed(heading);

  assign cos_c  = sat_trig(20'(cx >>> 14));
  assign sin_c  = sat_trig(20'(cy >>> 14));

  assign vx_sum = 27'(vx) + 27'($signed(prod[57:32]));
  assign vy_sum = 27'(vy) + 27'($signed(prod[57:32]));
  assign px_sum = 27'(px) + 27'($signed(prod[40:16]));
  assign py_sum = 27'(py) + 27'($signed(prod[40:16]));

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      dt   <= time_step;
      rate <= turn_rate;
      thr  <= thrust;
    end
    case (ctrl.op)
      htms_pkg::OP_HEAD_MUL,
      htms_pkg::OP_MUL_STHR,
      htms_pkg::OP_MUL_CTHR,
      htms_pkg::OP_MUL_PDT,
      htms_pkg::OP_MUL_VXDT,
      htms_pkg::OP_MUL_VYDT: prod <= mul_p;
      htms_pkg::OP_CORDIC_INIT: begin
        cx   <= htms_pkg::CORDIC_GAIN;
        cy   <= '0;
        cz   <= {z16, 16'h0000};
        flip <= heading[15] ^ heading[14];
        cnt  <= '0;
      end
      htms_pkg::OP_CORDIC_ITER: begin
        if (!cz[31]) begin
          cx <= cx - dx;
          cy <= cy + dy;
          cz <= cz - atan_v;
        end else begin
          cx <= cx + dx;
          cy <= cy - dy;
          cz <= cz + atan_v;
        end
        cnt <= cnt + 1'b1;
      end
      htms_pkg::OP_SINCOS: begin
        cos_v <= flip ? 18'(-cos_c) : cos_c;
        sin_v <= flip ? 18'(-sin_c) : sin_c;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heading <= '0;
      vx      <= '0;
      vy      <= '0;
      px      <= '0;
      py      <= '0;
    end else begin
      case (ctrl.op)
        htms_pkg::OP_HEAD_UPD: heading <= heading + prod[31:16];
        htms_pkg::OP_VX_UPD:   vx      <= sat24(vx_sum);
        htms_pkg::OP_VY_UPD:   vy      <= sat24(vy_sum);
        htms_pkg::OP_PX_UPD:   px      <= wrap(sat24(px_sum));
        htms_pkg::OP_PY_UPD:   py      <= wrap(sat24(py_sum));
        default: ;
      endcase
    end
  end

  assign status.iter_last = (cnt == htms_pkg::ITER_W'(ITERS - 1));

  assign pos_x = px[19:0];
  assign pos_y = py[19:0];
  assign vel_x = vx;
  assign vel_y = vy;
  assign angle = heading;

endmodule

// ===== design/heading_thrust_motion_step.sv =====
// Top level: stream handshake, microprogram sequencer and output register.
// Depends on htms_pkg, htms_ucode and htms_datapath.
//
//   channel  dir  fields
//   s_*      in   time_step, turn_rate, thrust
//   m_*      out  pos_x, pos_y, vel_x, vel_y, angle
//
// The CORDIC iteration step of the shared datapath repeats min(CORDIC_STEPS, 24) times per transaction;
// s_tready returns the cycle after the emit step loads the output register.
// A result waits in the output register while the next transaction is taken in.
// The program holds on its last step only while an earlier result is still untaken.
// Reset clears position, velocity, heading and the sequencer.
module heading_thrust_motion_step #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [55:0]  s_tdata,   // time_step[15:0], turn_rate[31:16], thrust[51:32]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata    // pos_x, pos_y, vel_x, vel_y, angle
);

  localparam int ITERS = (CORDIC_STEPS > htms_pkg::ATAN_LEN) ? htms_pkg::ATAN_LEN
                                                            : CORDIC_STEPS;

  htms_pkg::seq_state_t       state;
  htms_pkg::seq_state_t       state_next;
  logic [htms_pkg::PC_W-1:0]  pc;
  logic [htms_pkg::PC_W-1:0]  pc_next;
  htms_pkg::ctrl_word_t       word;
  htms_pkg::dp_ctrl_t         dp_ctrl;
  htms_pkg::dp_status_t       dp_status;
  logic                       out_load;
  logic                       s_accept;
  logic signed [19:0]         pos_x;
  logic signed [19:0]         pos_y;
  logic signed [23:0]         vel_x;
  logic signed [23:0]         vel_y;
  logic [15:0]                angle;

  htms_ucode u_ucode (
    .pc   (pc),
    .word (word)
  );

  htms_datapath #(
    .ITERS (ITERS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (dp_ctrl),
    .time_step (s_tdata[15:0]),
    .turn_rate ($signed(s_tdata[31:16])),
    .thrust    ($signed(s_tdata[51:32])),
    .status    (dp_status),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .angle     (angle)
  );

  assign s_tready     = (state == htms_pkg::SEQ_IDLE);
  assign s_accept     = s_tvalid && s_tready;
  assign dp_ctrl.load = s_accept;
  assign dp_ctrl.op   = (state == htms_pkg::SEQ_RUN) ? word.op : htms_pkg::OP_NOP;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= htms_pkg::SEQ_IDLE;
      pc    <= '0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end

  always_comb begin
    state_next = state;
    pc_next    = pc;
    out_load   = 1'b0;
    case (state)
      htms_pkg::SEQ_IDLE: begin
        if (s_tvalid) begin
          state_next = htms_pkg::SEQ_RUN;
          pc_next    = '0;
        end
      end
      htms_pkg::SEQ_RUN: begin
        if (word.op == htms_pkg::OP_EMIT) begin
          if (!m_tvalid || m_tready) begin
            out_load   = 1'b1;
            state_next = htms_pkg::SEQ_IDLE;
          end
        end else if (word.jump && !dp_status.iter_last) begin
          pc_next = word.target;
        end else begin
          pc_next = pc + 1'b1;
        end
      end
      default: state_next = htms_pkg::SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {angle, vel_y, vel_x, pos_y, pos_x};
    end
  end

`ifndef NO_ASSERTIONS
  a_start: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> (state == htms_pkg::SEQ_RUN) && (pc == '0))
    else $error("program did not start at step zero");

  a_emit_only: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == htms_pkg::SEQ_RUN && word.op == htms_pkg::OP_EMIT))
    else $error("result raised outside the emit step");

  a_no_abort: assert property (@(posedge clk) disable iff (rst)
    (state == htms_pkg::SEQ_RUN) && (word.op != htms_pkg::OP_EMIT) |=>
      (state == htms_pkg::SEQ_RUN))
    else $error("program left before its emit step");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("output register overwritten while still held");
`endif

endmodule
